// File: design/h264_sps_header_parser_unit_macros.svh
// Assertion macros used by the SPS parser checker.
`ifndef H264_SPS_HEADER_PARSER_UNIT_MACROS_SVH
`define H264_SPS_HEADER_PARSER_UNIT_MACROS_SVH

// Check that a condition implies a consequence in the same cycle.
`define SPS_ASSERT_NOW(lbl, cond, conseq, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (conseq)) \
    else $error(msg);

// Check that a condition implies a consequence in the next cycle.
`define SPS_ASSERT_NEXT(lbl, cond, conseq, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (conseq)) \
    else $error(msg);

`endif

// File: design/sps_hdr_pkg.sv
// Types, constants and helper functions of the SPS header parser.
package sps_hdr_pkg;

  localparam int MAX_LEADING_ZEROS_DEF = 31;
  localparam int SIZE_BITS_DEF         = 16;

  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_TRUNCATED = 2'd1;
  localparam logic [1:0] STATUS_BAD_VALUE = 2'd2;
  localparam logic [1:0] STATUS_CROP      = 2'd3;

  typedef struct packed {
    logic [7:0] sps_byte;
    logic       last_byte;
  } sps_in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [23:0] profile_level_word;
    logic [4:0]  param_set_id;
    logic [1:0]  chroma_format;
    logic [5:0]  log2_max_frame_number;
    logic [4:0]  order_count_type;
    logic [5:0]  log2_max_order_lsb;
    logic [7:0]  max_reference_frames;
    logic        frames_only;
    logic        vui_present;
    logic [15:0] picture_width;
    logic [15:0] picture_height;
  } sps_out_t;

  typedef enum logic [5:0] {
    SYN_PROFILE, SYN_CONSTR, SYN_LEVEL, SYN_ID, SYN_CHROMA, SYN_SEP, SYN_BDL,
    SYN_BDC, SYN_BYPASS, SYN_MATRIX, SYN_LISTFLAG, SYN_DELTA, SYN_FRAMENUM,
    SYN_POCTYPE, SYN_POCLSB, SYN_DPAZ, SYN_NONREF, SYN_T2B, SYN_CYCLE,
    SYN_REFOFF, SYN_MAXREF, SYN_GAPS, SYN_W, SYN_H, SYN_FMO, SYN_MBAFF,
    SYN_D8, SYN_CROPFLAG, SYN_CL, SYN_CR, SYN_CT, SYN_CB, SYN_VUI, SYN_DONE
  } syn_step_t;

  typedef enum logic [1:0] {
    CTL_IDLE, CTL_BITS, CTL_CALC, CTL_EMIT
  } ctl_state_t;

  typedef struct packed {
    logic load;   // capture the accepted byte
    logic shift;  // consume one bit
    logic calc;   // register crop sums
    logic emit;   // load result register and clear parse state
  } sps_cmd_t;

  typedef struct packed {
    logic halted; // parsing finished or failed, further bits are ignored
  } sps_stat_t;

  // Fixed length of an element; zero marks an exp-Golomb code.
  function automatic logic [5:0] elem_bits(input syn_step_t s);
    logic [5:0] n;
    case (s) inside
      SYN_PROFILE, SYN_CONSTR, SYN_LEVEL: n = 6'd8;
      SYN_SEP, SYN_BYPASS, SYN_MATRIX, SYN_LISTFLAG, SYN_DPAZ, SYN_GAPS,
      SYN_FMO, SYN_MBAFF, SYN_D8, SYN_CROPFLAG, SYN_VUI: n = 6'd1;
      default: n = 6'd0;
    endcase
    return n;
  endfunction

  function automatic logic is_high(input logic [7:0] p);
    logic h;
    case (p) inside
      8'd100, 8'd110, 8'd122, 8'd244, 8'd44, 8'd83, 8'd86, 8'd118, 8'd128,
      8'd138, 8'd139, 8'd134: h = 1'b1;
      default: h = 1'b0;
    endcase
    return h;
  endfunction

endpackage

// File: design/sps_hdr_ctrl.sv
// Sequencer of the SPS header parser: handshakes and bit stepping.
module sps_hdr_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  in_last,
  output logic                  out_valid,
  input  logic                  out_stall,
  output sps_hdr_pkg::sps_cmd_t cmd,
  input  sps_hdr_pkg::sps_stat_t stat
);

  sps_hdr_pkg::ctl_state_t state_r, state_nxt;
  logic [2:0] cnt_r, cnt_nxt;
  logic       last_r, last_nxt;
  logic       out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= sps_hdr_pkg::CTL_IDLE;
      cnt_r       <= 3'd0;
      last_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      last_r      <= last_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    last_nxt      = last_r;
    out_valid_nxt = out_valid_r && out_stall;
    cmd           = '0;
    in_stall      = 1'b1;
    case (state_r)
      sps_hdr_pkg::CTL_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load  = 1'b1;
          last_nxt  = in_last;
          cnt_nxt   = 3'd0;
          state_nxt = sps_hdr_pkg::CTL_BITS;
        end
      end
      sps_hdr_pkg::CTL_BITS: begin
        cmd.shift = !stat.halted;
        cnt_nxt   = cnt_r + 3'd1;
        if (cnt_r == 3'd7 || stat.halted) begin
          state_nxt = last_r ? sps_hdr_pkg::CTL_CALC : sps_hdr_pkg::CTL_IDLE;
        end
      end
      sps_hdr_pkg::CTL_CALC: begin
        cmd.calc  = 1'b1;
        state_nxt = sps_hdr_pkg::CTL_EMIT;
      end
      sps_hdr_pkg::CTL_EMIT: begin
        if (!out_valid_r || !out_stall) begin
          cmd.emit      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = sps_hdr_pkg::CTL_IDLE;
        end
      end
      default: state_nxt = sps_hdr_pkg::CTL_IDLE;
    endcase
  end

  assign out_valid = out_valid_r;

endmodule

// File: design/sps_hdr_datapath.sv
// Bit parser, syntax registers, crop arithmetic and result register.
module sps_hdr_datapath #(
  parameter int MAX_LEADING_ZEROS = sps_hdr_pkg::MAX_LEADING_ZEROS_DEF,
  parameter int SIZE_BITS         = sps_hdr_pkg::SIZE_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic [7:0]             in_byte,
  input  sps_hdr_pkg::sps_cmd_t  cmd,
  output sps_hdr_pkg::sps_stat_t stat,
  output sps_hdr_pkg::sps_out_t  out_data
);

  localparam int LZW = $clog2(MAX_LEADING_ZEROS + 1);
  localparam int CW  = (SIZE_BITS + 5 > 35) ? SIZE_BITS + 5 : 35;
  localparam logic [32:0] W_LIM = 33'((64'd1 << (SIZE_BITS - 4)) - 64'd1);
  localparam logic [32:0] H_LIM = 33'((64'd1 << SIZE_BITS) - 64'd1);
  localparam logic [SIZE_BITS-1:0] F1_LIM =
    SIZE_BITS'((64'd1 << (SIZE_BITS - 4)) - 64'd1);
  localparam logic [SIZE_BITS-1:0] F0_LIM =
    SIZE_BITS'((64'd1 << (SIZE_BITS - 5)) - 64'd1);

  logic [7:0]             byte_r, byte_nxt;
  sps_hdr_pkg::syn_step_t step_r, step_nxt;
  logic [LZW-1:0]         lz_r, lz_nxt;
  logic [31:0]            acc_r, acc_nxt;
  logic [5:0]             sbl_r, sbl_nxt;
  logic                   suffix_r, suffix_nxt;
  logic [3:0]             list_r, list_nxt;
  logic [6:0]             coef_r, coef_nxt;
  logic [7:0]             prev_r, prev_nxt;
  logic [7:0]             cyc_r, cyc_nxt;
  logic [23:0]            hdr_r, hdr_nxt;
  logic [1:0]             chroma_r, chroma_nxt;
  logic                   sep_r, sep_nxt;
  logic [4:0]             id_r, id_nxt;
  logic [5:0]             fnum_r, fnum_nxt;
  logic [4:0]             poct_r, poct_nxt;
  logic [5:0]             lsb_r, lsb_nxt;
  logic [7:0]             maxref_r, maxref_nxt;
  logic                   fmo_r, fmo_nxt;
  logic                   vui_r, vui_nxt;
  logic                   err_r, err_nxt;
  logic                   fin_r, fin_nxt;
  logic [SIZE_BITS-1:0]   size_r [2];
  logic [SIZE_BITS-1:0]   size_nxt [2];
  logic [31:0]            crop_r [4];
  logic [31:0]            crop_nxt [4];
  logic [CW-1:0]          cx_r, cy_r, w_r, h_r;
  sps_hdr_pkg::sps_out_t  out_r;

  // bit-level scratch
  logic                   b;
  logic [31:0]            acc_sh;
  logic                   done;
  logic [31:0]            v;
  logic                   go;
  sps_hdr_pkg::syn_step_t go_step;
  logic [7:0]             nx;
  logic [6:0]             coef_inc;
  logic [3:0]             list_inc;
  logic                   next_list;
  logic [1:0]             cat;
  logic                   fr2;
  logic [32:0]            sum_x, sum_y;
  sps_hdr_pkg::sps_out_t  res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r   <= sps_hdr_pkg::SYN_PROFILE;
      lz_r     <= '0;
      acc_r    <= '0;
      sbl_r    <= 6'd8;
      suffix_r <= 1'b0;
      list_r   <= '0;
      coef_r   <= '0;
      prev_r   <= 8'd8;
      cyc_r    <= '0;
      hdr_r    <= '0;
      chroma_r <= 2'd1;
      sep_r    <= 1'b0;
      id_r     <= '0;
      fnum_r   <= '0;
      poct_r   <= '0;
      lsb_r    <= '0;
      maxref_r <= '0;
      fmo_r    <= 1'b0;
      vui_r    <= 1'b0;
      err_r    <= 1'b0;
      fin_r    <= 1'b0;
      for (int i = 0; i < 2; i++) size_r[i] <= '0;
      for (int i = 0; i < 4; i++) crop_r[i] <= '0;
    end else begin
      step_r   <= step_nxt;
      lz_r     <= lz_nxt;
      acc_r    <= acc_nxt;
      sbl_r    <= sbl_nxt;
      suffix_r <= suffix_nxt;
      list_r   <= list_nxt;
      coef_r   <= coef_nxt;
      prev_r   <= prev_nxt;
      cyc_r    <= cyc_nxt;
      hdr_r    <= hdr_nxt;
      chroma_r <= chroma_nxt;
      sep_r    <= sep_nxt;
      id_r     <= id_nxt;
      fnum_r   <= fnum_nxt;
      poct_r   <= poct_nxt;
      lsb_r    <= lsb_nxt;
      maxref_r <= maxref_nxt;
      fmo_r    <= fmo_nxt;
      vui_r    <= vui_nxt;
      err_r    <= err_nxt;
      fin_r    <= fin_nxt;
      for (int i = 0; i < 2; i++) size_r[i] <= size_nxt[i];
      for (int i = 0; i < 4; i++) crop_r[i] <= crop_nxt[i];
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    byte_r <= byte_nxt;
    if (cmd.calc) begin
      cx_r <= CW'(sum_x) << ((cat == 2'd1 || cat == 2'd2) ? 1 : 0);
      cy_r <= CW'(sum_y) << ((fr2 ? 1 : 0) + ((cat == 2'd1) ? 1 : 0));
      w_r  <= CW'(size_r[0]) << 4;
      h_r  <= CW'(size_r[1]) << (fr2 ? 5 : 4);
    end
    if (cmd.emit) begin
      out_r <= res;
    end
  end

  assign stat.halted = fin_r || (step_r == sps_hdr_pkg::SYN_DONE);
  assign b      = byte_r[7];
  assign acc_sh = {acc_r[30:0], b};
  assign cat    = (sep_r || chroma_r == 2'd0) ? 2'd0 : chroma_r;
  assign fr2    = !fmo_r;
  assign sum_x  = {1'b0, crop_r[0]} + {1'b0, crop_r[1]};
  assign sum_y  = {1'b0, crop_r[2]} + {1'b0, crop_r[3]};

  // Bit decode and element completion
  always_comb begin
    byte_nxt   = cmd.load ? in_byte : (cmd.shift ? {byte_r[6:0], 1'b0} : byte_r);
    step_nxt   = step_r;
    lz_nxt     = lz_r;
    acc_nxt    = acc_r;
    sbl_nxt    = sbl_r;
    suffix_nxt = suffix_r;
    list_nxt   = list_r;
    coef_nxt   = coef_r;
    prev_nxt   = prev_r;
    cyc_nxt    = cyc_r;
    hdr_nxt    = hdr_r;
    chroma_nxt = chroma_r;
    sep_nxt    = sep_r;
    id_nxt     = id_r;
    fnum_nxt   = fnum_r;
    poct_nxt   = poct_r;
    lsb_nxt    = lsb_r;
    maxref_nxt = maxref_r;
    fmo_nxt    = fmo_r;
    vui_nxt    = vui_r;
    err_nxt    = err_r;
    fin_nxt    = fin_r;
    size_nxt   = size_r;
    crop_nxt   = crop_r;
    done       = 1'b0;
    v          = '0;
    go         = 1'b0;
    go_step    = step_r;
    nx         = '0;
    coef_inc   = coef_r + 7'd1;
    list_inc   = list_r + 4'd1;
    next_list  = 1'b0;

    if (cmd.shift && !stat.halted) begin
      if (sps_hdr_pkg::elem_bits(step_r) != 6'd0) begin
        acc_nxt = acc_sh;
        sbl_nxt = sbl_r - 6'd1;
        if (sbl_r == 6'd1) begin
          done = 1'b1;
          v    = acc_sh;
        end
      end else if (!suffix_r) begin
        if (!b) begin
          if (32'(lz_r) >= 32'(MAX_LEADING_ZEROS)) begin
            err_nxt = 1'b1;
            fin_nxt = 1'b1;
          end else begin
            lz_nxt = lz_r + LZW'(1);
          end
        end else if (lz_r == '0) begin
          done = 1'b1;
        end else begin
          suffix_nxt = 1'b1;
          sbl_nxt    = 6'(lz_r);
          acc_nxt    = '0;
        end
      end else begin
        acc_nxt = acc_sh;
        sbl_nxt = sbl_r - 6'd1;
        if (sbl_r == 6'd1) begin
          done = 1'b1;
          v    = ((32'd1 << lz_r) - 32'd1) + acc_sh;
        end
      end
    end

    if (done) begin
      case (step_r)
        sps_hdr_pkg::SYN_PROFILE: begin
          hdr_nxt = {16'd0, v[7:0]};
          go = 1'b1; go_step = sps_hdr_pkg::SYN_CONSTR;
        end
        sps_hdr_pkg::SYN_CONSTR: begin
          hdr_nxt[15:8] = v[7:0];
          go = 1'b1; go_step = sps_hdr_pkg::SYN_LEVEL;
        end
        sps_hdr_pkg::SYN_LEVEL: begin
          hdr_nxt[23:16] = v[7:0];
          go = 1'b1; go_step = sps_hdr_pkg::SYN_ID;
        end
        sps_hdr_pkg::SYN_ID: begin
          if (v > 32'd31) begin
            err_nxt = 1'b1; fin_nxt = 1'b1;
          end else begin
            id_nxt  = v[4:0];
            go      = 1'b1;
            go_step = sps_hdr_pkg::is_high(hdr_r[7:0]) ? sps_hdr_pkg::SYN_CHROMA
                                                       : sps_hdr_pkg::SYN_FRAMENUM;
          end
        end
        sps_hdr_pkg::SYN_CHROMA: begin
          if (v > 32'd3) begin
            err_nxt = 1'b1; fin_nxt = 1'b1;
          end else begin
            chroma_nxt = v[1:0];
            go         = 1'b1;
            go_step    = (v == 32'd3) ? sps_hdr_pkg::SYN_SEP : sps_hdr_pkg::SYN_BDL;
          end
        end
        sps_hdr_pkg::SYN_SEP: begin
          sep_nxt = v[0];
          go = 1'b1; go_step = sps_hdr_pkg::SYN_BDL;
        end
        sps_hdr_pkg::SYN_BDL: begin
          go = 1'b1; go_step = sps_hdr_pkg::SYN_BDC;
        end
        sps_hdr_pkg::SYN_BDC: begin
          go = 1'b1; go_step = sps_hdr_pkg::SYN_BYPASS;
        end
        sps_hdr_pkg::SYN_BYPASS: begin
          go = 1'b1; go_step = sps_hdr_pkg::SYN_MATRIX;
        end
        sps_hdr_pkg::SYN_MATRIX: begin
          go = 1'b1;
          if (v[0]) begin
            list_nxt = '0;
            go_step  = sps_hdr_pkg::SYN_LISTFLAG;
          end else begin
            go_step  = sps_hdr_pkg::SYN_FRAMENUM;
          end
        end
        sps_hdr_pkg::SYN_LISTFLAG: begin
          if (v[0]) begin
            prev_nxt = 8'd8;
            coef_nxt = '0;
            go = 1'b1; go_step = sps_hdr_pkg::SYN_DELTA;
          end else begin
            next_list = 1'b1;
          end
        end
        sps_hdr_pkg::SYN_DELTA: begin
          // delta_scale folds mod 256, only the low nine bits of the code matter
          if (v[0]) nx = prev_r + v[8:1] + 8'd1;
          else      nx = prev_r - v[8:1];
          if (nx != 8'd0) prev_nxt = nx;
          coef_nxt = coef_inc;
          if (coef_inc < ((list_r < 4'd6) ? 7'd16 : 7'd64) && nx != 8'd0) begin
            go = 1'b1; go_step = sps_hdr_pkg::SYN_DELTA;
          end else begin
            next_list = 1'b1;
          end
        end
        sps_hdr_pkg::SYN_FRAMENUM: begin
          if (v > 32'd59) begin
            err_nxt = 1'b1; fin_nxt = 1'b1;
          end else begin
            fnum_nxt = v[5:0] + 6'd4;
            go = 1'b1; go_step = sps_hdr_pkg::SYN_POCTYPE;
          end
        end
        sps_hdr_pkg::SYN_POCTYPE: begin
          if (v > 32'd28) begin
            err_nxt = 1'b1; fin_nxt = 1'b1;
          end else begin
            poct_nxt = v[4:0];
            go       = 1'b1;
            if (v == 32'd0)      go_step = sps_hdr_pkg::SYN_POCLSB;
            else if (v == 32'd1) go_step = sps_hdr_pkg::SYN_DPAZ;
            else                 go_step = sps_hdr_pkg::SYN_MAXREF;
          end
        end
        sps_hdr_pkg::SYN_POCLSB: begin
          if (v > 32'd28) begin
            err_nxt = 1'b1; fin_nxt = 1'b1;
          end else begin
            lsb_nxt = v[5:0] + 6'd4;
            go = 1'b1; go_step = sps_hdr_pkg::SYN_MAXREF;
          end
        end
        sps_hdr_pkg::SYN_DPAZ: begin
          go = 1'b1; go_step = sps_hdr_pkg::SYN_NONREF;
        end
        sps_hdr_pkg::SYN_NONREF: begin
          go = 1'b1; go_step = sps_hdr_pkg::SYN_T2B;
        end
        sps_hdr_pkg::SYN_T2B: begin
          go = 1'b1; go_step = sps_hdr_pkg::SYN_CYCLE;
        end
        sps_hdr_pkg::SYN_CYCLE: begin
          if (v > 32'd255) begin
            err_nxt = 1'b1; fin_nxt = 1'b1;
          end else begin
            cyc_nxt = v[7:0];
            go      = 1'b1;
            go_step = (v == 32'd0) ? sps_hdr_pkg::SYN_MAXREF : sps_hdr_pkg::SYN_REFOFF;
          end
        end
        sps_hdr_pkg::SYN_REFOFF: begin
          cyc_nxt = cyc_r - 8'd1;
          go      = 1'b1;
          go_step = (cyc_r == 8'd1) ? sps_hdr_pkg::SYN_MAXREF : sps_hdr_pkg::SYN_REFOFF;
        end
        sps_hdr_pkg::SYN_MAXREF: begin
          if (v > 32'd255) begin
            err_nxt = 1'b1; fin_nxt = 1'b1;
          end else begin
            maxref_nxt = v[7:0];
            go = 1'b1; go_step = sps_hdr_pkg::SYN_GAPS;
          end
        end
        sps_hdr_pkg::SYN_GAPS: begin
          go = 1'b1; go_step = sps_hdr_pkg::SYN_W;
        end
        sps_hdr_pkg::SYN_W: begin
          if ({1'b0, v} >= W_LIM) begin
            err_nxt = 1'b1; fin_nxt = 1'b1;
          end else begin
            size_nxt[0] = SIZE_BITS'(v + 32'd1);
            go = 1'b1; go_step = sps_hdr_pkg::SYN_H;
          end
        end
        sps_hdr_pkg::SYN_H: begin
          if ({1'b0, v} >= H_LIM) begin
            err_nxt = 1'b1; fin_nxt = 1'b1;
          end else begin
            size_nxt[1] = SIZE_BITS'(v + 32'd1);
            go = 1'b1; go_step = sps_hdr_pkg::SYN_FMO;
          end
        end
        sps_hdr_pkg::SYN_FMO: begin
          fmo_nxt = v[0];
          if (size_r[1] > (v[0] ? F1_LIM : F0_LIM)) begin
            err_nxt = 1'b1; fin_nxt = 1'b1;
          end else begin
            go      = 1'b1;
            go_step = v[0] ? sps_hdr_pkg::SYN_D8 : sps_hdr_pkg::SYN_MBAFF;
          end
        end
        sps_hdr_pkg::SYN_MBAFF: begin
          go = 1'b1; go_step = sps_hdr_pkg::SYN_D8;
        end
        sps_hdr_pkg::SYN_D8: begin
          go = 1'b1; go_step = sps_hdr_pkg::SYN_CROPFLAG;
        end
        sps_hdr_pkg::SYN_CROPFLAG: begin
          go      = 1'b1;
          go_step = v[0] ? sps_hdr_pkg::SYN_CL : sps_hdr_pkg::SYN_VUI;
        end
        sps_hdr_pkg::SYN_CL: begin
          crop_nxt[0] = v;
          go = 1'b1; go_step = sps_hdr_pkg::SYN_CR;
        end
        sps_hdr_pkg::SYN_CR: begin
          crop_nxt[1] = v;
          go = 1'b1; go_step = sps_hdr_pkg::SYN_CT;
        end
        sps_hdr_pkg::SYN_CT: begin
          crop_nxt[2] = v;
          go = 1'b1; go_step = sps_hdr_pkg::SYN_CB;
        end
        sps_hdr_pkg::SYN_CB: begin
          crop_nxt[3] = v;
          go = 1'b1; go_step = sps_hdr_pkg::SYN_VUI;
        end
        sps_hdr_pkg::SYN_VUI: begin
          vui_nxt = v[0];
          fin_nxt = 1'b1;
          go = 1'b1; go_step = sps_hdr_pkg::SYN_DONE;
        end
        default: go = 1'b0;
      endcase
    end

    if (next_list) begin
      list_nxt = list_inc;
      go       = 1'b1;
      go_step  = (list_inc < ((chroma_r == 2'd3) ? 4'd12 : 4'd8))
                 ? sps_hdr_pkg::SYN_LISTFLAG : sps_hdr_pkg::SYN_FRAMENUM;
    end

    // enter the next element
    if (go) begin
      step_nxt   = go_step;
      lz_nxt     = '0;
      acc_nxt    = '0;
      suffix_nxt = 1'b0;
      sbl_nxt    = sps_hdr_pkg::elem_bits(go_step);
    end

    // result taken: back to the start of a new parameter set
    if (cmd.emit) begin
      step_nxt   = sps_hdr_pkg::SYN_PROFILE;
      lz_nxt     = '0;
      acc_nxt    = '0;
      sbl_nxt    = 6'd8;
      suffix_nxt = 1'b0;
      list_nxt   = '0;
      coef_nxt   = '0;
      prev_nxt   = 8'd8;
      cyc_nxt    = '0;
      hdr_nxt    = '0;
      chroma_nxt = 2'd1;
      sep_nxt    = 1'b0;
      id_nxt     = '0;
      fnum_nxt   = '0;
      poct_nxt   = '0;
      lsb_nxt    = '0;
      maxref_nxt = '0;
      fmo_nxt    = 1'b0;
      vui_nxt    = 1'b0;
      err_nxt    = 1'b0;
      fin_nxt    = 1'b0;
      for (int i = 0; i < 2; i++) size_nxt[i] = '0;
      for (int i = 0; i < 4; i++) crop_nxt[i] = '0;
    end
  end

  // Result word from the registered crop terms
  always_comb begin
    res = '0;
    if (err_r) begin
      res.status = sps_hdr_pkg::STATUS_BAD_VALUE;
    end else if (step_r != sps_hdr_pkg::SYN_DONE) begin
      res.status = sps_hdr_pkg::STATUS_TRUNCATED;
    end else if (cx_r >= w_r || cy_r >= h_r) begin
      res.status = sps_hdr_pkg::STATUS_CROP;
    end else begin
      res.status                = sps_hdr_pkg::STATUS_OK;
      res.profile_level_word    = hdr_r;
      res.param_set_id          = id_r;
      res.chroma_format         = chroma_r;
      res.log2_max_frame_number = fnum_r;
      res.order_count_type      = poct_r;
      res.log2_max_order_lsb    = (poct_r == 5'd0) ? lsb_r : 6'd0;
      res.max_reference_frames  = maxref_r;
      res.frames_only           = fmo_r;
      res.vui_present           = vui_r;
      res.picture_width         = 16'(w_r - cx_r);
      res.picture_height        = 16'(h_r - cy_r);
    end
  end

  assign out_data = out_r;

endmodule

// File: design/h264_sps_header_parser_unit.sv
// Top level of the H.264 sequence parameter set header parser.
// Takes the RBSP bytes of one sequence parameter set, one byte per input
// beat, and decodes them bit by bit, MSB first, through the syntax up to
// vui_parameters_present_flag (high profile chroma, bit depth and scaling
// lists, POC types 0 and 1 included). On the beat marked last_byte a single
// result beat follows with a status (ok, truncated, bad value or code, crop
// too large), the profile/level word, ids, flags and the cropped picture
// size; on a nonzero status all other fields are zero. Bits after the VUI
// flag or after an error are ignored until the last byte.
// Per byte: it is accepted, then its eight bits are shifted through the
// bit-serial decoder before another is taken; once parsing has stopped no
// bits are shifted. After the last byte the crop sums are registered and
// the result register is loaded. The next byte is accepted while a result
// still waits on out_stall; a second set's result waits until the register is free.
module h264_sps_header_parser_unit #(
  parameter int MAX_LEADING_ZEROS = sps_hdr_pkg::MAX_LEADING_ZEROS_DEF,
  parameter int SIZE_BITS         = sps_hdr_pkg::SIZE_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  sps_hdr_pkg::sps_in_t  in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output sps_hdr_pkg::sps_out_t out_data
);

  sps_hdr_pkg::sps_cmd_t  cmd;
  sps_hdr_pkg::sps_stat_t stat;

  // sequencer: handshakes, bit count, result valid
  sps_hdr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_last   (in_data.last_byte),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .stat      (stat)
  );

  // parser state, crop arithmetic and result register
  sps_hdr_datapath #(
    .MAX_LEADING_ZEROS (MAX_LEADING_ZEROS),
    .SIZE_BITS         (SIZE_BITS)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_byte  (in_data.sps_byte),
    .cmd      (cmd),
    .stat     (stat),
    .out_data (out_data)
  );

endmodule

// File: design/sps_hdr_checker.sv
// Port-level checker of the SPS header parser, bound to the top level.
`include "h264_sps_header_parser_unit_macros.svh"

module sps_hdr_checker (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_valid,
  input logic                  in_stall,
  input sps_hdr_pkg::sps_in_t  in_data,
  input logic                  out_valid,
  input logic                  out_stall,
  input sps_hdr_pkg::sps_out_t out_data
);

  `SPS_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data), "stalled result beat changed")
  `SPS_ASSERT_NEXT(a_byte_busy, in_valid && !in_stall, in_stall, "byte accepted while previous still shifting")
  `SPS_ASSERT_NOW(a_err_zero, out_valid && out_data.status != sps_hdr_pkg::STATUS_OK, out_data.profile_level_word == 24'd0 && out_data.picture_width == 16'd0 && out_data.picture_height == 16'd0, "error result carries data")
  `SPS_ASSERT_NOW(a_ok_fnum, out_valid && out_data.status == sps_hdr_pkg::STATUS_OK, out_data.log2_max_frame_number >= 6'd4, "frame number size below minimum")

endmodule

bind h264_sps_header_parser_unit sps_hdr_checker u_sps_hdr_checker (.*);

// File: test/h264_sps_header_parser_unit_test.sv
// Self-checking testbench of the H.264 SPS header parser: table-driven and random streams.
`timescale 1ns / 100ps

module h264_sps_header_parser_unit_test;
  import sps_hdr_pkg::*;

  localparam int MAX_LZ    = MAX_LEADING_ZEROS_DEF;
  localparam int PIX_LIMIT = (1 << SIZE_BITS_DEF) - 1;
  localparam int CYCLE_LIMIT = 1500000;

  logic     clk;
  logic     rst_n;
  logic     in_valid;
  logic     in_stall;
  sps_in_t  in_data;
  logic     out_valid;
  logic     out_stall;
  sps_out_t out_data;

  h264_sps_header_parser_unit u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Parser shadow state: mirrors the block's syntax walk bit by bit.
  syn_step_t   p_step;
  int unsigned p_lz, p_acc, p_left, p_list, p_coef, p_prev, p_cyc;
  logic [23:0] p_hdr;
  int unsigned p_chroma, p_sep, p_id, p_fnum, p_poct, p_lsb, p_maxref;
  int unsigned p_fmo, p_vui;
  bit          p_err, p_suffix, p_fin;
  int unsigned p_size [2];
  int unsigned p_crop [4];

  sps_out_t sps_result_q[$];
  bit       failed;
  int       n_results;

  // Fixed element length; zero marks exp-Golomb.
  function automatic int unsigned fixed_len(syn_step_t s);
    case (s)
      SYN_PROFILE, SYN_CONSTR, SYN_LEVEL: return 8;
      SYN_SEP, SYN_BYPASS, SYN_MATRIX, SYN_LISTFLAG, SYN_DPAZ, SYN_GAPS,
      SYN_FMO, SYN_MBAFF, SYN_D8, SYN_CROPFLAG, SYN_VUI: return 1;
      default: return 0;
    endcase
  endfunction

  function automatic bit high_profile(logic [7:0] p);
    case (p)
      8'd100, 8'd110, 8'd122, 8'd244, 8'd44, 8'd83, 8'd86, 8'd118,
      8'd128, 8'd138, 8'd139, 8'd134: return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  task automatic goto_step(syn_step_t s);
    p_step = s;
    p_lz = 0;
    p_acc = 0;
    p_suffix = 0;
    p_left = fixed_len(s);
  endtask

  task automatic parse_clear();
    p_chroma = 1; p_sep = 0; p_id = 0; p_fnum = 0; p_poct = 0; p_lsb = 0;
    p_maxref = 0; p_fmo = 0; p_vui = 0; p_err = 0;
    p_list = 0; p_coef = 0; p_prev = 8; p_cyc = 0; p_hdr = '0;
    p_size[0] = 0; p_size[1] = 0;
    foreach (p_crop[i]) p_crop[i] = 0;
    p_fin = 0;
    goto_step(SYN_PROFILE);
  endtask

  task automatic abort_parse();
    p_err = 1;
    p_fin = 1;
  endtask

  task automatic advance_list();
    p_list++;
    if (p_list < ((p_chroma == 3) ? 12 : 8)) goto_step(SYN_LISTFLAG);
    else goto_step(SYN_FRAMENUM);
  endtask

  task automatic finish_element(int unsigned v);
    int unsigned nx;
    case (p_step)
      SYN_PROFILE: begin p_hdr[7:0] = v; goto_step(SYN_CONSTR); end
      SYN_CONSTR:  begin p_hdr[15:8] = v; goto_step(SYN_LEVEL); end
      SYN_LEVEL:   begin p_hdr[23:16] = v; goto_step(SYN_ID); end
      SYN_ID: begin
        if (v > 31) abort_parse();
        else begin
          p_id = v;
          goto_step(high_profile(p_hdr[7:0]) ? SYN_CHROMA : SYN_FRAMENUM);
        end
      end
      SYN_CHROMA: begin
        if (v > 3) abort_parse();
        else begin
          p_chroma = v;
          goto_step(v == 3 ? SYN_SEP : SYN_BDL);
        end
      end
      SYN_SEP:    begin p_sep = v; goto_step(SYN_BDL); end
      SYN_BDL:    goto_step(SYN_BDC);
      SYN_BDC:    goto_step(SYN_BYPASS);
      SYN_BYPASS: goto_step(SYN_MATRIX);
      SYN_MATRIX: begin
        if (v != 0) begin p_list = 0; goto_step(SYN_LISTFLAG); end
        else goto_step(SYN_FRAMENUM);
      end
      SYN_LISTFLAG: begin
        if (v != 0) begin p_prev = 8; p_coef = 0; goto_step(SYN_DELTA); end
        else advance_list();
      end
      SYN_DELTA: begin
        // delta_scale wraps mod 256
        if (v & 1) nx = (p_prev + (v >> 1) + 1) & 255;
        else nx = (p_prev - (v >> 1)) & 255;
        if (nx != 0) p_prev = nx;
        p_coef++;
        if (p_coef < ((p_list < 6) ? 16 : 64) && nx != 0) goto_step(SYN_DELTA);
        else advance_list();
      end
      SYN_FRAMENUM: begin
        if (v > 59) abort_parse();
        else begin p_fnum = v + 4; goto_step(SYN_POCTYPE); end
      end
      SYN_POCTYPE: begin
        if (v > 28) abort_parse();
        else begin
          p_poct = v;
          goto_step(v == 0 ? SYN_POCLSB : (v == 1 ? SYN_DPAZ : SYN_MAXREF));
        end
      end
      SYN_POCLSB: begin
        if (v > 28) abort_parse();
        else begin p_lsb = v + 4; goto_step(SYN_MAXREF); end
      end
      SYN_DPAZ:   goto_step(SYN_NONREF);
      SYN_NONREF: goto_step(SYN_T2B);
      SYN_T2B:    goto_step(SYN_CYCLE);
      SYN_CYCLE: begin
        if (v > 255) abort_parse();
        else begin
          p_cyc = v;
          goto_step(v == 0 ? SYN_MAXREF : SYN_REFOFF);
        end
      end
      SYN_REFOFF: begin
        p_cyc = (p_cyc - 1) & 255;
        goto_step(p_cyc == 0 ? SYN_MAXREF : SYN_REFOFF);
      end
      SYN_MAXREF: begin
        if (v > 255) abort_parse();
        else begin p_maxref = v; goto_step(SYN_GAPS); end
      end
      SYN_GAPS: goto_step(SYN_W);
      SYN_W: begin
        if ((longint'(v) + 1) * 16 > PIX_LIMIT) abort_parse();
        else begin p_size[0] = v + 1; goto_step(SYN_H); end
      end
      SYN_H: begin
        if (longint'(v) + 1 > PIX_LIMIT) abort_parse();
        else begin p_size[1] = v + 1; goto_step(SYN_FMO); end
      end
      SYN_FMO: begin
        p_fmo = v;
        if (longint'(p_size[1]) * 16 * (2 - v) > PIX_LIMIT) abort_parse();
        else goto_step(v == 0 ? SYN_MBAFF : SYN_D8);
      end
      SYN_MBAFF:    goto_step(SYN_D8);
      SYN_D8:       goto_step(SYN_CROPFLAG);
      SYN_CROPFLAG: goto_step(v != 0 ? SYN_CL : SYN_VUI);
      SYN_CL: begin p_crop[0] = v; goto_step(SYN_CR); end
      SYN_CR: begin p_crop[1] = v; goto_step(SYN_CT); end
      SYN_CT: begin p_crop[2] = v; goto_step(SYN_CB); end
      SYN_CB: begin p_crop[3] = v; goto_step(SYN_VUI); end
      SYN_VUI: begin p_vui = v; p_fin = 1; goto_step(SYN_DONE); end
      default: ;
    endcase
  endtask

  task automatic consume_bit(bit b);
    if (p_fin || p_step == SYN_DONE) return;
    if (fixed_len(p_step) != 0) begin
      p_acc = (p_acc << 1) | b;
      p_left--;
      if (p_left == 0) finish_element(p_acc);
      return;
    end
    if (!p_suffix) begin
      if (!b) begin
        if (p_lz >= MAX_LZ) abort_parse();
        else p_lz++;
      end else if (p_lz == 0) begin
        finish_element(0);
      end else begin
        p_suffix = 1;
        p_left = p_lz;
        p_acc = 0;
      end
      return;
    end
    p_acc = (p_acc << 1) | b;
    p_left--;
    if (p_left == 0) finish_element(((32'd1 << p_lz) - 1) + p_acc);
  endtask

  // Feed one accepted beat to the shadow parser; queue a result on last_byte.
  task automatic predict_sps(sps_in_t beat);
    sps_out_t    r;
    int unsigned fr, cat, ux, uy;
    longint      w, h, cx, cy;
    for (int i = 7; i >= 0; i--) consume_bit(beat.sps_byte[i]);
    if (!beat.last_byte) return;
    r = '0;
    if (p_err) r.status = STATUS_BAD_VALUE;
    else if (p_step != SYN_DONE) r.status = STATUS_TRUNCATED;
    else begin
      fr  = 2 - (p_fmo & 1);
      cat = (p_sep != 0 || p_chroma == 0) ? 0 : p_chroma;
      ux  = (cat == 1 || cat == 2) ? 2 : 1;
      uy  = fr * ((cat == 1) ? 2 : 1);
      w   = longint'(p_size[0]) * 16;
      h   = longint'(p_size[1]) * 16 * fr;
      cx  = (longint'(p_crop[0]) + p_crop[1]) * ux;
      cy  = (longint'(p_crop[2]) + p_crop[3]) * uy;
      if (cx >= w || cy >= h) r.status = STATUS_CROP;
      else begin
        r.status                = STATUS_OK;
        r.profile_level_word    = p_hdr;
        r.param_set_id          = p_id[4:0];
        r.chroma_format         = p_chroma[1:0];
        r.log2_max_frame_number = p_fnum[5:0];
        r.order_count_type      = p_poct[4:0];
        r.log2_max_order_lsb    = (p_poct == 0) ? p_lsb[5:0] : 6'd0;
        r.max_reference_frames  = p_maxref[7:0];
        r.frames_only           = p_fmo[0];
        r.vui_present           = p_vui[0];
        r.picture_width         = 16'(w - cx);
        r.picture_height        = 16'(h - cy);
      end
    end
    sps_result_q.push_back(r);
    parse_clear();
  endtask

  // Bit writer used to build streams; flushes to a byte list.
  bit     bitbuf[$];
  sps_in_t beat_q[$];

  task automatic put_bits(int unsigned v, int n);
    for (int i = n - 1; i >= 0; i--) bitbuf.push_back(v[i]);
  endtask

  task automatic put_ue(int unsigned v);
    longint unsigned x;
    int              nb;
    x = longint'(v) + 1;
    nb = 0;
    while ((x >> nb) > 1) nb++;
    for (int i = 0; i < nb; i++) bitbuf.push_back(1'b0);
    for (int i = nb; i >= 0; i--) bitbuf.push_back(x[i]);
  endtask

  // Close the bit buffer into beats, optionally truncated or padded.
  task automatic flush_beats(int drop, int pad);
    sps_in_t b;
    int      nbytes;
    bitbuf.push_back(1'b1);
    while (bitbuf.size() % 8 != 0) bitbuf.push_back(1'b0);
    for (int i = 0; i < pad; i++) put_bits($urandom_range(255), 8);
    nbytes = bitbuf.size() / 8 - drop;
    if (nbytes < 1) nbytes = 1;
    for (int i = 0; i < nbytes; i++) begin
      for (int k = 0; k < 8; k++) b.sps_byte[7 - k] = bitbuf[i * 8 + k];
      b.last_byte = (i == nbytes - 1);
      beat_q.push_back(b);
    end
    bitbuf.delete();
  endtask

  // Build one SPS with random content, at times truncated; wild widens the field ranges.
  task automatic build_sps(bit wild);
    int unsigned prof, chroma, poct, ncyc, hmb, fmo, nl;
    int unsigned profs [12] = '{100, 110, 122, 244, 44, 83, 86, 118, 128, 138, 139, 134};
    prof = ($urandom_range(1) != 0) ? profs[$urandom_range(11)] : $urandom_range(255);
    put_bits(prof, 8);
    put_bits($urandom_range(255), 8);
    put_bits($urandom_range(255), 8);
    put_ue(wild ? $urandom_range(33) : $urandom_range(31));
    if (high_profile(prof)) begin
      chroma = wild ? $urandom_range(4) : $urandom_range(3);
      put_ue(chroma);
      if (chroma == 3) put_bits($urandom_range(1), 1);
      put_ue($urandom_range(6));
      put_ue($urandom_range(6));
      put_bits($urandom_range(1), 1);
      if ($urandom_range(2) == 0) begin
        put_bits(1, 1);
        nl = (chroma == 3) ? 12 : 8;
        for (int l = 0; l < nl; l++) begin
          put_bits($urandom_range(1), 1);
          if (bitbuf[$]) begin
            for (int c = 0; c < $urandom_range(20); c++) put_ue($urandom_range(300));
            put_ue(16); // one more delta: subtracts 8 from the last scale
          end
        end
      end else put_bits(0, 1);
    end
    put_ue(wild ? $urandom_range(61) : $urandom_range(59));
    poct = ($urandom_range(5) == 0) ? (wild ? $urandom_range(30) : $urandom_range(28))
                                    : $urandom_range(1);
    put_ue(poct);
    if (poct == 0) put_ue(wild ? $urandom_range(30) : $urandom_range(28));
    else if (poct == 1) begin
      put_bits($urandom_range(1), 1);
      put_ue($urandom_range(1000));
      put_ue($urandom_range(1000));
      ncyc = wild ? $urandom_range(257) : $urandom_range(6);
      put_ue(ncyc);
      if (ncyc <= 255) for (int i = 0; i < ncyc; i++) put_ue($urandom_range(40));
    end
    put_ue(wild ? $urandom_range(257) : $urandom_range(16));
    put_bits($urandom_range(1), 1);
    put_ue(wild ? $urandom_range(4096) : $urandom_range(119));
    hmb = wild ? $urandom_range(4096) : $urandom_range(67);
    put_ue(hmb);
    fmo = $urandom_range(1);
    put_bits(fmo, 1);
    if (fmo == 0) put_bits($urandom_range(1), 1);
    put_bits($urandom_range(1), 1);
    if ($urandom_range(1) != 0) begin
      put_bits(1, 1);
      for (int i = 0; i < 4; i++)
        put_ue(($urandom_range(7) == 0) ? $urandom_range(2000) : $urandom_range(8));
    end else put_bits(0, 1);
    put_bits($urandom_range(1), 1);
    flush_beats(($urandom_range(9) == 0) ? $urandom_range(1, 6) : 0, $urandom_range(2));
  endtask

  // Directed stimulus: payload bytes, last flag, and where plain, the status.
  typedef struct {
    logic [7:0] b;
    bit         last;
    bit         has_exp;
    logic [1:0] st;
  } dir_row_t;

  dir_row_t dir_tab [] = '{
    // single byte sets: each is truncated
    '{8'h42, 1, 1, STATUS_TRUNCATED},
    '{8'h00, 1, 1, STATUS_TRUNCATED},
    '{8'hff, 1, 1, STATUS_TRUNCATED},
    // baseline: id with too many leading zeros is a bad code
    '{8'h42, 0, 0, 0}, '{8'hc0, 0, 0, 0}, '{8'h1e, 0, 0, 0},
    '{8'h00, 0, 0, 0}, '{8'h00, 0, 0, 0}, '{8'h00, 0, 0, 0},
    '{8'h00, 0, 0, 0}, '{8'h01, 1, 1, STATUS_BAD_VALUE},
    // baseline 640x480 stream, checked by prediction
    '{8'h42, 0, 0, 0}, '{8'h00, 0, 0, 0}, '{8'h1f, 0, 0, 0},
    '{8'hf4, 0, 0, 0}, '{8'h05, 0, 0, 0}, '{8'h01, 0, 0, 0},
    '{8'he8, 0, 0, 0}, '{8'h80, 0, 0, 0}, '{8'h6c, 0, 0, 0},
    '{8'h80, 0, 0, 0}, '{8'hff, 1, 0, 0}
  };

  sps_in_t   stim_q[$];
  bit        stim_exp_has[$];
  logic[1:0] stim_exp_st[$];
  bit        dir_has [$];
  logic[1:0] dir_st [$];

  int  send_idle_pct, recv_idle_pct;
  bit  hold_off;
  bit  stim_done;
  longint cycles;

  // Sender: drive beats at the rising edge, advance only on acceptance.
  initial begin
    sps_in_t nxt;
    in_valid = 1'b0;
    in_data  = '0;
    wait (rst_n);
    while (!stim_done || stim_q.size() != 0) begin
      @(posedge clk);
      if (in_valid && !in_stall) begin
        predict_sps(in_data);
        if (in_data.last_byte && dir_has.size() != 0) begin
          if (dir_has[0]) begin
            sps_result_q[$].status = dir_st[0];
          end
          void'(dir_has.pop_front());
          void'(dir_st.pop_front());
        end
      end
      if (!in_valid || !in_stall) begin
        if (stim_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          nxt = stim_q.pop_front();
          in_data  <= nxt;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
    // drain the final offered beat
    while (in_valid) begin
      @(posedge clk);
      if (in_valid && !in_stall) begin
        predict_sps(in_data);
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: random stall, or a long hold-off when asked.
  initial begin
    out_stall = 1'b1;
    wait (rst_n);
    forever begin
      @(posedge clk);
      if (out_valid && !out_stall) begin
        if (sps_result_q.size() == 0) begin
          $error("result beat with no expectation");
          failed = 1;
        end else begin
          sps_out_t e;
          e = sps_result_q.pop_front();
          n_results++;
          if (e.status != out_data.status) begin
            $error("status exp %0d got %0d", e.status, out_data.status); failed = 1;
          end
          if (e.profile_level_word != out_data.profile_level_word) begin
            $error("profile_level_word exp %0h got %0h", e.profile_level_word,
                   out_data.profile_level_word); failed = 1;
          end
          if (e.param_set_id != out_data.param_set_id) begin
            $error("param_set_id exp %0d got %0d", e.param_set_id,
                   out_data.param_set_id); failed = 1;
          end
          if (e.chroma_format != out_data.chroma_format) begin
            $error("chroma_format exp %0d got %0d", e.chroma_format,
                   out_data.chroma_format); failed = 1;
          end
          if (e.log2_max_frame_number != out_data.log2_max_frame_number) begin
            $error("log2_max_frame_number exp %0d got %0d", e.log2_max_frame_number,
                   out_data.log2_max_frame_number); failed = 1;
          end
          if (e.order_count_type != out_data.order_count_type) begin
            $error("order_count_type exp %0d got %0d", e.order_count_type,
                   out_data.order_count_type); failed = 1;
          end
          if (e.log2_max_order_lsb != out_data.log2_max_order_lsb) begin
            $error("log2_max_order_lsb exp %0d got %0d", e.log2_max_order_lsb,
                   out_data.log2_max_order_lsb); failed = 1;
          end
          if (e.max_reference_frames != out_data.max_reference_frames) begin
            $error("max_reference_frames exp %0d got %0d", e.max_reference_frames,
                   out_data.max_reference_frames); failed = 1;
          end
          if (e.frames_only != out_data.frames_only) begin
            $error("frames_only exp %0d got %0d", e.frames_only,
                   out_data.frames_only); failed = 1;
          end
          if (e.vui_present != out_data.vui_present) begin
            $error("vui_present exp %0d got %0d", e.vui_present,
                   out_data.vui_present); failed = 1;
          end
          if (e.picture_width != out_data.picture_width) begin
            $error("picture_width exp %0d got %0d", e.picture_width,
                   out_data.picture_width); failed = 1;
          end
          if (e.picture_height != out_data.picture_height) begin
            $error("picture_height exp %0d got %0d", e.picture_height,
                   out_data.picture_height); failed = 1;
          end
        end
      end
      out_stall <= hold_off || ($urandom_range(99) < recv_idle_pct);
    end
  end

  // Watchdog: a cycle counter bounds the run.
  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  // Long hold-off: stall the receiver while the sender keeps offering beats.
  task automatic long_hold_off(int n);
    @(posedge clk);
    hold_off = 1'b1;
    for (int i = 0; i < n; i++) @(posedge clk);
    hold_off = 1'b0;
  endtask

  // Wait for the stimulus queue to empty, then for outstanding results.
  task automatic drain_phase();
    while (stim_q.size() != 0 || in_valid || sps_result_q.size() != 0) @(posedge clk);
  endtask

  // Queue random streams until about the requested byte count is reached.
  task automatic queue_random(int nbytes);
    int start;
    start = stim_q.size();
    while (stim_q.size() - start < nbytes) begin
      if ($urandom_range(9) == 0) begin
        // noise: random bytes with random last marks
        for (int i = 0; i < $urandom_range(1, 6); i++) begin
          sps_in_t b;
          b.sps_byte  = $urandom_range(255);
          b.last_byte = ($urandom_range(3) == 0);
          stim_q.push_back(b);
        end
      end else begin
        build_sps($urandom_range(3) == 0);
        while (beat_q.size() != 0) stim_q.push_back(beat_q.pop_front());
      end
    end
    // end on a last byte so the set closes
    if (!stim_q[$].last_byte) begin
      sps_in_t b;
      b.sps_byte  = $urandom_range(255);
      b.last_byte = 1'b1;
      stim_q.push_back(b);
    end
  endtask

  initial begin
    failed        = 0;
    n_results     = 0;
    hold_off      = 0;
    stim_done     = 0;
    send_idle_pct = 34;
    recv_idle_pct = 56;
    parse_clear();
    rst_n = 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Directed table; a typed-in status overrides only rows read off at a glance.
    foreach (dir_tab[i]) begin
      sps_in_t b;
      b.sps_byte  = dir_tab[i].b;
      b.last_byte = dir_tab[i].last;
      stim_q.push_back(b);
      if (dir_tab[i].last) begin
        dir_has.push_back(dir_tab[i].has_exp);
        dir_st.push_back(dir_tab[i].st);
      end
    end
    drain_phase();

    queue_random(270);
    fork
      long_hold_off(400);
    join_none
    drain_phase();

    send_idle_pct = 56;
    recv_idle_pct = 34;
    queue_random(270);
    drain_phase();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    queue_random(260);
    stim_done = 1;
    drain_phase();
    repeat (40) @(posedge clk);

    if (!failed && sps_result_q.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+design
design/sps_hdr_pkg.sv
design/sps_hdr_ctrl.sv
design/sps_hdr_datapath.sv
design/h264_sps_header_parser_unit.sv
design/sps_hdr_checker.sv
test/h264_sps_header_parser_unit_test.sv
